// ----- rtl/core/pea_pkg.sv -----
package pea_pkg;

  localparam int unsigned NODES      = 4;
  localparam int unsigned NODE_W     = $clog2(NODES);
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned DIG_W      = 16;
  localparam int unsigned PROD_W     = 2 * ACC_W;
  localparam int unsigned N_DIGITS   = ACC_W / DIG_W;
  localparam int unsigned DIGIT_CW   = $clog2(N_DIGITS);
  localparam int unsigned N_STIFF    = NODES * NODES;
  localparam int unsigned STIFF_W    = $clog2(N_STIFF);
  localparam int unsigned N_ENTRIES  = NODES + N_STIFF;
  localparam int unsigned ENTRY_CW   = $clog2(N_ENTRIES + 1);
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic signed [ACC_W-1:0] S48_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S48_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [31:0] UPPER_UNBOUNDED = 32'h7FFF_FFFF;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMPED = 3'd6;

  localparam logic KIND_FORCE = 1'b0;
  localparam logic KIND_STIFF = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TGT, ST_DOT, ST_ERR, ST_FRC, ST_WF, ST_WK, ST_FA, ST_FORCE,
    ST_STIFF, ST_REACT, ST_LW, ST_LFN, ST_LWFN, ST_LSTIFF, ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic                    s16;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] res;
  } mul_rsp_t;

  function automatic logic signed [ACC_W-1:0] sat_add48(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b,
    input logic                    sub
  );
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    begin
      if (sub) begin
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
      end else begin
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      end
      if (s[ACC_W] != s[ACC_W-1]) begin
        r = s[ACC_W] ? S48_MIN : S48_MAX;
      end else begin
        r = s[ACC_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

// ----- rtl/core/pea_mul.sv -----
// Sequential signed multiplier: magnitudes are multiplied one 16-bit digit of b
// per cycle, most significant digit first, then shifted right by 14 or 16 with
// truncation toward zero and saturated to the signed 48-bit range.
module pea_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pea_pkg::mul_req_t req_i,
  output pea_pkg::mul_rsp_t rsp_o
);

  logic [pea_pkg::ACC_W-1:0]    ma_q, ma_d, mb_q, mb_d;
  logic                         neg_q, neg_d, s16_q, s16_d;
  logic [pea_pkg::PROD_W-1:0]   acc_q, acc_d;
  logic [pea_pkg::DIGIT_CW-1:0] cnt_q, cnt_d;
  logic                         run_q, run_d, fin_q, fin_d, done_q, done_d;
  logic signed [pea_pkg::ACC_W-1:0] res_q, res_d;

  logic [pea_pkg::DIG_W-1:0]    digit;
  logic [pea_pkg::PROD_W-1:0]   shifted;
  logic [pea_pkg::ACC_W-1:0]    lim, mag;

  always_comb begin
    digit = mb_q[cnt_q*pea_pkg::DIG_W +: pea_pkg::DIG_W];
    shifted = s16_q ? (acc_q >> 16) : (acc_q >> 14);
    lim = neg_q ? {1'b1, {(pea_pkg::ACC_W-1){1'b0}}} : {1'b0, {(pea_pkg::ACC_W-1){1'b1}}};
    if ((|shifted[pea_pkg::PROD_W-1:pea_pkg::ACC_W]) || (shifted[pea_pkg::ACC_W-1:0] > lim)) begin
      mag = lim;
    end else begin
      mag = shifted[pea_pkg::ACC_W-1:0];
    end

    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    s16_d  = s16_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      ma_d  = req_i.a[pea_pkg::ACC_W-1] ? -req_i.a : req_i.a;
      mb_d  = req_i.b[pea_pkg::ACC_W-1] ? -req_i.b : req_i.b;
      neg_d = req_i.a[pea_pkg::ACC_W-1] ^ req_i.b[pea_pkg::ACC_W-1];
      s16_d = req_i.s16;
      acc_d = '0;
      cnt_d = pea_pkg::DIGIT_CW'(pea_pkg::N_DIGITS - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = {acc_q[pea_pkg::PROD_W-pea_pkg::DIG_W-1:0], {pea_pkg::DIG_W{1'b0}}}
            + (pea_pkg::PROD_W'(ma_q) * pea_pkg::PROD_W'(digit));
      if (cnt_q == '0) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (fin_q) begin
      res_d  = neg_q ? -mag : mag;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
    s16_q <= s16_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ----- rtl/core/penalty_element_assembly.sv -----
// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+-------------------------------------
// input     | in        | in_valid_i/in_stall_o  | req_type, node_slot, node_value,
//           |           |                        | shape_0..3, point_weight, last_point
// result    | out       | out_valid_o/out_stall_i| entry_kind, row/col_node, entry_value,
//           |           |                        | reaction_total, last_entry
// config    | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Load and start-pass words never stall the input. Every product goes through the
// shared multiplier, so an integration point stalls the input for 32 products and
// two steps without a product in consistent mode and for 5 products in lumped
// mode. The last point of an element adds 12 products and 20 output words.
// The multiplier resolves one 16-bit digit per cycle.
// Reset clears control state and the accumulators and sets the configuration registers to their defaults.
// A stalled output word holds in the output register; the input side is taken
// again as soon as the sequencer is idle, even while the final word waits.
module penalty_element_assembly (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       req_type_i,
  input  logic [pea_pkg::NODE_W-1:0]       node_slot_i,
  input  logic signed [pea_pkg::VALUE_BITS-1:0] node_value_i,
  input  logic signed [15:0]               shape_0_i,
  input  logic signed [15:0]               shape_1_i,
  input  logic signed [15:0]               shape_2_i,
  input  logic signed [15:0]               shape_3_i,
  input  logic [31:0]                      point_weight_i,
  input  logic                             last_point_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             entry_kind_o,
  output logic [pea_pkg::NODE_W-1:0]       row_node_o,
  output logic [pea_pkg::NODE_W-1:0]       col_node_o,
  output logic signed [pea_pkg::ACC_W-1:0] entry_value_o,
  output logic signed [pea_pkg::ACC_W-1:0] reaction_total_o,
  output logic                             last_entry_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pea_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int unsigned AW = pea_pkg::ACC_W;
  localparam int unsigned NW = pea_pkg::NODE_W;
  localparam int unsigned SW = pea_pkg::STIFF_W;

  // Configuration registers.
  logic [31:0] gain_q, offset_q, rate_q, time_q, upper_q;
  logic [30:0] step_q;
  logic        lumped_q;

  pea_pkg::seq_state_e state_q, state_d;
  logic issued_q, issued_d;

  logic signed [pea_pkg::VALUE_BITS-1:0] node_q [pea_pkg::NODES];
  logic signed [AW-1:0] force_q [pea_pkg::NODES];
  logic signed [AW-1:0] stiff_q [pea_pkg::N_STIFF];
  logic signed [AW-1:0] lw_q    [pea_pkg::NODES];
  logic signed [AW-1:0] react_q;

  logic signed [15:0] sh_q [pea_pkg::NODES];
  logic [31:0] w_q;
  logic        last_q, mode_q;

  logic signed [AW-1:0] tgt_q, dot_q, frc_q, wf_q, wk_q, a_q, fn_q;
  logic [NW-1:0] n_q, r_q, c_q;
  logic [pea_pkg::ENTRY_CW-1:0] ocnt_q;

  logic                 out_valid_q, out_kind_q, out_last_q;
  logic [NW-1:0]        out_row_q, out_col_q;
  logic signed [AW-1:0] out_val_q, out_react_q;

  pea_pkg::mul_req_t mul_req;
  pea_pkg::mul_rsp_t mul_rsp;

  logic in_acc, in_window, is_mul, emit_load, emit_last;
  logic signed [32:0] t_sum;
  logic [NW-1:0] sh_addr, f_addr;
  logic [SW-1:0] s_addr;
  logic signed [AW-1:0] sh_sel, x_sel, k_ext, w_ext;
  logic [SW-1:0] emit_idx;

  assign in_stall_o  = (state_q != pea_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign in_window = (upper_q == pea_pkg::UPPER_UNBOUNDED) ||
                     ($signed(time_q) < $signed(upper_q));
  assign t_sum     = $signed({time_q[31], time_q}) + $signed({2'b00, step_q});
  assign k_ext     = {{(AW-32){1'b0}}, gain_q};
  assign w_ext     = {{(AW-32){1'b0}}, w_q};

  assign emit_idx  = SW'(ocnt_q - pea_pkg::ENTRY_CW'(pea_pkg::NODES));
  assign emit_load = (state_q == pea_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign emit_last = (ocnt_q == pea_pkg::ENTRY_CW'(pea_pkg::N_ENTRIES - 1));

  // One shared read address per small array.
  always_comb begin
    case (state_q)
      pea_pkg::ST_FA, pea_pkg::ST_FORCE: sh_addr = r_q;
      pea_pkg::ST_STIFF:                 sh_addr = c_q;
      default:                           sh_addr = n_q;
    endcase
    case (state_q)
      pea_pkg::ST_FORCE: f_addr = r_q;
      pea_pkg::ST_EMIT:  f_addr = ocnt_q[NW-1:0];
      default:           f_addr = n_q;
    endcase
    case (state_q)
      pea_pkg::ST_STIFF: s_addr = {r_q, c_q};
      pea_pkg::ST_EMIT:  s_addr = emit_idx;
      default:           s_addr = {n_q, n_q};
    endcase
    sh_sel = {{(AW-16){sh_q[sh_addr][15]}}, sh_q[sh_addr]};
    x_sel  = {{(AW-pea_pkg::VALUE_BITS){node_q[n_q][pea_pkg::VALUE_BITS-1]}}, node_q[n_q]};
  end

  // Sequencer: next state and multiplier operands.
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    is_mul  = 1'b1;
    case (state_q)
      pea_pkg::ST_TGT: begin
        mul_req.a = {{(AW-32){rate_q[31]}}, rate_q};
        mul_req.b = {{(AW-33){t_sum[32]}}, t_sum};
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) state_d = mode_q ? pea_pkg::ST_LW : pea_pkg::ST_DOT;
      end
      pea_pkg::ST_DOT: begin
        mul_req.a = sh_sel;
        mul_req.b = x_sel;
        if (mul_rsp.done && n_q == NW'(pea_pkg::NODES - 1)) state_d = pea_pkg::ST_ERR;
      end
      pea_pkg::ST_FRC: begin
        mul_req.a = k_ext;
        mul_req.b = dot_q;
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) state_d = pea_pkg::ST_WF;
      end
      pea_pkg::ST_WF: begin
        mul_req.a = w_ext;
        mul_req.b = frc_q;
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) state_d = pea_pkg::ST_WK;
      end
      pea_pkg::ST_WK: begin
        mul_req.a = w_ext;
        mul_req.b = k_ext;
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) state_d = pea_pkg::ST_FA;
      end
      pea_pkg::ST_FA: begin
        mul_req.a = wk_q;
        mul_req.b = sh_sel;
        if (mul_rsp.done) state_d = pea_pkg::ST_FORCE;
      end
      pea_pkg::ST_FORCE: begin
        mul_req.a = sh_sel;
        mul_req.b = wf_q;
        if (mul_rsp.done) state_d = pea_pkg::ST_STIFF;
      end
      pea_pkg::ST_STIFF: begin
        mul_req.a = a_q;
        mul_req.b = sh_sel;
        if (mul_rsp.done && c_q == NW'(pea_pkg::NODES - 1)) begin
          state_d = (r_q == NW'(pea_pkg::NODES - 1)) ? pea_pkg::ST_REACT : pea_pkg::ST_FA;
        end
      end
      pea_pkg::ST_LW: begin
        mul_req.a = w_ext;
        mul_req.b = sh_sel;
        if (mul_rsp.done && n_q == NW'(pea_pkg::NODES - 1)) begin
          state_d = last_q ? pea_pkg::ST_LFN : pea_pkg::ST_IDLE;
        end
      end
      pea_pkg::ST_LFN: begin
        mul_req.a = k_ext;
        mul_req.b = pea_pkg::sat_add48(x_sel, tgt_q, 1'b1);
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) state_d = pea_pkg::ST_LWFN;
      end
      pea_pkg::ST_LWFN: begin
        mul_req.a = lw_q[n_q];
        mul_req.b = fn_q;
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) state_d = pea_pkg::ST_LSTIFF;
      end
      pea_pkg::ST_LSTIFF: begin
        mul_req.a = lw_q[n_q];
        mul_req.b = k_ext;
        mul_req.s16 = 1'b1;
        if (mul_rsp.done) begin
          state_d = (n_q == NW'(pea_pkg::NODES - 1)) ? pea_pkg::ST_EMIT : pea_pkg::ST_LFN;
        end
      end
      pea_pkg::ST_ERR: begin
        is_mul = 1'b0;
        state_d = pea_pkg::ST_FRC;
      end
      pea_pkg::ST_REACT: begin
        is_mul = 1'b0;
        state_d = last_q ? pea_pkg::ST_LFN : pea_pkg::ST_IDLE;
      end
      pea_pkg::ST_EMIT: begin
        is_mul = 1'b0;
        if (emit_load && emit_last) state_d = pea_pkg::ST_IDLE;
      end
      default: begin
        is_mul = 1'b0;
        if (in_acc && req_type_i == pea_pkg::REQ_POINT && in_window) begin
          state_d = pea_pkg::ST_TGT;
        end
      end
    endcase
    mul_req.start = is_mul && !issued_q;
    if (!is_mul || mul_rsp.done) begin
      issued_d = 1'b0;
    end else begin
      issued_d = 1'b1;
    end
  end

  pea_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pea_pkg::ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 32'h0001_0000;
      offset_q <= '0;
      rate_q   <= '0;
      time_q   <= '0;
      step_q   <= '0;
      upper_q  <= pea_pkg::UPPER_UNBOUNDED;
      lumped_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pea_pkg::CFG_GAIN:   gain_q   <= cfg_data_i;
        pea_pkg::CFG_OFFSET: offset_q <= cfg_data_i;
        pea_pkg::CFG_RATE:   rate_q   <= cfg_data_i;
        pea_pkg::CFG_TIME:   time_q   <= cfg_data_i;
        pea_pkg::CFG_STEP:   step_q   <= cfg_data_i[30:0];
        pea_pkg::CFG_UPPER:  upper_q  <= cfg_data_i;
        pea_pkg::CFG_LUMPED: lumped_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Node values have no reset; a slot is defined once it has been loaded.
  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == pea_pkg::REQ_LOAD) begin
      node_q[node_slot_i] <= node_value_i;
    end
    if (in_acc && req_type_i == pea_pkg::REQ_POINT) begin
      sh_q[0] <= shape_0_i;
      sh_q[1] <= shape_1_i;
      sh_q[2] <= shape_2_i;
      sh_q[3] <= shape_3_i;
      w_q     <= point_weight_i;
      last_q  <= last_point_i;
      mode_q  <= lumped_q;
    end
  end

  // Accumulators, temporaries and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(pea_pkg::NODES); i++) begin
        force_q[i] <= '0;
        lw_q[i]    <= '0;
      end
      for (int i = 0; i < int'(pea_pkg::N_STIFF); i++) stiff_q[i] <= '0;
      react_q     <= '0;
      n_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      ocnt_q      <= '0;
      out_valid_q <= 1'b0;
      tgt_q <= '0; dot_q <= '0; frc_q <= '0; wf_q <= '0;
      wk_q  <= '0; a_q   <= '0; fn_q  <= '0;
      out_kind_q <= 1'b0; out_last_q <= 1'b0; out_row_q <= '0; out_col_q <= '0;
      out_val_q  <= '0;   out_react_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit_load) out_valid_q <= 1'b0;
      case (state_q)
        pea_pkg::ST_IDLE: begin
          if (in_acc && req_type_i == pea_pkg::REQ_START) react_q <= '0;
          if (in_acc && req_type_i == pea_pkg::REQ_POINT) begin
            n_q <= '0;
            r_q <= '0;
            c_q <= '0;
            dot_q <= '0;
            // A last point outside the time window only drops the element.
            if (!in_window && last_point_i) begin
              for (int i = 0; i < int'(pea_pkg::NODES); i++) begin
                force_q[i] <= '0;
                lw_q[i]    <= '0;
              end
              for (int i = 0; i < int'(pea_pkg::N_STIFF); i++) stiff_q[i] <= '0;
            end
          end
        end
        pea_pkg::ST_TGT: if (mul_rsp.done) begin
          tgt_q <= pea_pkg::sat_add48({{(AW-32){offset_q[31]}}, offset_q}, mul_rsp.res, 1'b0);
        end
        pea_pkg::ST_DOT: if (mul_rsp.done) begin
          dot_q <= pea_pkg::sat_add48(dot_q, mul_rsp.res, 1'b0);
          n_q   <= n_q + 1'b1;
        end
        pea_pkg::ST_ERR: dot_q <= pea_pkg::sat_add48(dot_q, tgt_q, 1'b1);
        pea_pkg::ST_FRC: if (mul_rsp.done) frc_q <= mul_rsp.res;
        pea_pkg::ST_WF:  if (mul_rsp.done) wf_q  <= mul_rsp.res;
        pea_pkg::ST_WK:  if (mul_rsp.done) wk_q  <= mul_rsp.res;
        pea_pkg::ST_FA:  if (mul_rsp.done) a_q   <= mul_rsp.res;
        pea_pkg::ST_FORCE: if (mul_rsp.done) begin
          force_q[f_addr] <= pea_pkg::sat_add48(force_q[f_addr], mul_rsp.res, 1'b1);
          c_q <= '0;
        end
        pea_pkg::ST_STIFF: if (mul_rsp.done) begin
          stiff_q[s_addr] <= pea_pkg::sat_add48(stiff_q[s_addr], mul_rsp.res, 1'b1);
          c_q <= c_q + 1'b1;
          if (c_q == NW'(pea_pkg::NODES - 1)) r_q <= r_q + 1'b1;
        end
        pea_pkg::ST_REACT: begin
          react_q <= pea_pkg::sat_add48(react_q, wf_q, 1'b0);
          n_q     <= '0;
        end
        pea_pkg::ST_LW: if (mul_rsp.done) begin
          lw_q[n_q] <= pea_pkg::sat_add48(lw_q[n_q], mul_rsp.res, 1'b0);
          n_q <= n_q + 1'b1;
        end
        pea_pkg::ST_LFN: if (mul_rsp.done) fn_q <= mul_rsp.res;
        pea_pkg::ST_LWFN: if (mul_rsp.done) begin
          force_q[f_addr] <= pea_pkg::sat_add48(force_q[f_addr], mul_rsp.res, 1'b1);
          react_q <= pea_pkg::sat_add48(react_q, mul_rsp.res, 1'b0);
        end
        pea_pkg::ST_LSTIFF: if (mul_rsp.done) begin
          stiff_q[s_addr] <= pea_pkg::sat_add48(stiff_q[s_addr], mul_rsp.res, 1'b1);
          n_q    <= n_q + 1'b1;
          ocnt_q <= '0;
        end
        pea_pkg::ST_EMIT: if (emit_load) begin
          out_valid_q <= 1'b1;
          out_react_q <= react_q;
          out_last_q  <= emit_last;
          ocnt_q      <= ocnt_q + 1'b1;
          if (ocnt_q < pea_pkg::ENTRY_CW'(pea_pkg::NODES)) begin
            out_kind_q <= pea_pkg::KIND_FORCE;
            out_row_q  <= ocnt_q[NW-1:0];
            out_col_q  <= '0;
            out_val_q  <= force_q[f_addr];
          end else begin
            out_kind_q <= pea_pkg::KIND_STIFF;
            out_row_q  <= emit_idx[SW-1:NW];
            out_col_q  <= emit_idx[NW-1:0];
            out_val_q  <= stiff_q[s_addr];
          end
          // The element is closed once its final word is in the output register.
          if (emit_last) begin
            for (int i = 0; i < int'(pea_pkg::NODES); i++) begin
              force_q[i] <= '0;
              lw_q[i]    <= '0;
            end
            for (int i = 0; i < int'(pea_pkg::N_STIFF); i++) stiff_q[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entry_kind_o     = out_kind_q;
  assign row_node_o       = out_row_q;
  assign col_node_o       = out_col_q;
  assign entry_value_o    = out_val_q;
  assign reaction_total_o = out_react_q;
  assign last_entry_o     = out_last_q;

  // The sequencer never leaves a multiplication outstanding when idle.
  a_idle_no_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pea_pkg::ST_IDLE) |-> !issued_q)
    else $error("multiplier still issued while idle");

  // A multiplier result only arrives for an issued request.
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> issued_q)
    else $error("unexpected multiplier result");

  // The final word of an element is the last diagonal stiffness entry.
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_entry_o) |->
      (entry_kind_o == pea_pkg::KIND_STIFF && row_node_o == NW'(pea_pkg::NODES - 1) &&
       col_node_o == NW'(pea_pkg::NODES - 1)))
    else $error("last word is not the final stiffness entry");

  // Word counter stays within one element's worth of words.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= pea_pkg::ENTRY_CW'(pea_pkg::N_ENTRIES))
    else $error("word counter out of range");

endmodule

// ----- sim/penalty_element_assembly_tb.sv -----
`timescale 1ns / 100ps

// Testbench for the penalty element assembly kernel.
// A queue of pending input words is filled by the stimulus process, and a
// falling-edge driver presents them with random idle cycles. Each word that
// the block accepts is run through a local fixed-point predictor. The
// predictor appends the entries that the word should produce to a queue.
// A rising-edge monitor compares each accepted output word, field by field,
// with the oldest entry in that queue.
module penalty_element_assembly_tb;

  localparam int  CLK_HALF   = 6;
  localparam int  DRAIN_WAIT = 400;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct {
    logic [1:0]         req;
    logic [1:0]         slot;
    logic signed [31:0] value;
    logic signed [15:0] shape [pea_pkg::NODES];
    logic [31:0]        weight;
    logic               last;
  } in_word_t;

  typedef struct {
    logic        kind;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [47:0] value;
    logic [47:0] react;
    logic        last;
  } entry_t;

  logic clk_i, rst_ni;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [pea_pkg::NODE_W-1:0] node_slot_i = '0;
  logic signed [pea_pkg::VALUE_BITS-1:0] node_value_i = '0;
  logic signed [15:0] shape_0_i = '0;
  logic signed [15:0] shape_1_i = '0;
  logic signed [15:0] shape_2_i = '0;
  logic signed [15:0] shape_3_i = '0;
  logic [31:0] point_weight_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic entry_kind_o;
  logic [pea_pkg::NODE_W-1:0] row_node_o, col_node_o;
  logic signed [pea_pkg::ACC_W-1:0] entry_value_o, reaction_total_o;
  logic last_entry_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [pea_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  penalty_element_assembly uut (.*);

  // Pending words, predicted entries and the run bookkeeping.
  in_word_t pending_words [$];
  entry_t   expected_entries [$];
  in_word_t cur_word;
  int       words_issued = 0;
  int       words_taken = 0;
  int       mismatches = 0;
  bit       quiet_stretch;
  longint   cycle_count = 0;

  // Predictor copy of the configuration and of the element state.
  longint gain_q, offset_q, rate_q, time_q, step_q, upper_q;
  bit     lumped_q;
  longint node_q [pea_pkg::NODES] = '{default: 0};
  longint force_q [pea_pkg::NODES] = '{default: 0};
  longint stiff_q [pea_pkg::N_STIFF] = '{default: 0};
  longint lweight_q [pea_pkg::NODES] = '{default: 0};
  longint react_q = 0;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic longint clamp48(input longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  // Exact product shifted right by s, truncated toward zero, then clamped.
  function automatic longint fx_mul(input longint a, input longint b, input int s);
    logic [127:0] prod;
    logic [63:0]  ua, ub, lim;
    bit           neg;
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    neg  = (a < 0) != (b < 0);
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod >> s;
    lim  = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    if (prod > {64'd0, lim}) prod = {64'd0, lim};
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic entry_t make_entry(input logic kind, input int row, input int col,
                                        input longint value, input bit last);
    entry_t e;
    e.kind  = kind;
    e.row   = row[1:0];
    e.col   = col[1:0];
    e.value = value[47:0];
    e.react = react_q[47:0];
    e.last  = last;
    return e;
  endfunction

  function automatic void clear_element();
    foreach (force_q[i]) force_q[i] = 0;
    foreach (stiff_q[i]) stiff_q[i] = 0;
    foreach (lweight_q[i]) lweight_q[i] = 0;
  endfunction

  function automatic void set_register(input logic [pea_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [31:0] d);
    case (idx)
      pea_pkg::CFG_GAIN:   gain_q   = longint'($unsigned(d));
      pea_pkg::CFG_OFFSET: offset_q = longint'($signed(d));
      pea_pkg::CFG_RATE:   rate_q   = longint'($signed(d));
      pea_pkg::CFG_TIME:   time_q   = longint'($signed(d));
      pea_pkg::CFG_STEP:   step_q   = longint'($unsigned(d[30:0]));
      pea_pkg::CFG_UPPER:  upper_q  = longint'($signed(d));
      pea_pkg::CFG_LUMPED: lumped_q = d[0];
      default: ;
    endcase
  endfunction

  // Advance the element state by one accepted word and queue its entries.
  function automatic void assemble_word(input in_word_t w);
    longint tgt, dot, err, frc, wf, wk, a, fn, wfn, wt;
    longint sh [pea_pkg::NODES];
    bit     active;
    dot = 0;
    if (w.req == pea_pkg::REQ_LOAD) begin
      node_q[w.slot] = longint'(w.value);
      return;
    end
    if (w.req == pea_pkg::REQ_START) begin
      react_q = 0;
      return;
    end
    if (w.req != pea_pkg::REQ_POINT) return;
    active = (upper_q == longint'(pea_pkg::UPPER_UNBOUNDED)) || (time_q < upper_q);
    if (!active) begin
      if (w.last) clear_element();
      return;
    end
    wt  = longint'(w.weight);
    tgt = clamp48(offset_q + fx_mul(rate_q, time_q + step_q, 16));
    for (int n = 0; n < pea_pkg::NODES; n++) sh[n] = longint'(w.shape[n]);
    if (!lumped_q) begin
      for (int n = 0; n < pea_pkg::NODES; n++)
        dot = clamp48(dot + fx_mul(sh[n], node_q[n], 14));
      err = clamp48(dot - tgt);
      frc = fx_mul(gain_q, err, 16);
      wf  = fx_mul(wt, frc, 16);
      wk  = fx_mul(wt, gain_q, 16);
      for (int r = 0; r < pea_pkg::NODES; r++) begin
        a = fx_mul(wk, sh[r], 14);
        force_q[r] = clamp48(force_q[r] - fx_mul(sh[r], wf, 14));
        for (int c = 0; c < pea_pkg::NODES; c++)
          stiff_q[r*pea_pkg::NODES+c] =
            clamp48(stiff_q[r*pea_pkg::NODES+c] - fx_mul(a, sh[c], 14));
      end
      react_q = clamp48(react_q + wf);
    end else begin
      for (int n = 0; n < pea_pkg::NODES; n++)
        lweight_q[n] = clamp48(lweight_q[n] + fx_mul(wt, sh[n], 14));
    end
    if (!w.last) return;
    // Lumped weights are applied on the diagonal when the element closes.
    for (int n = 0; n < pea_pkg::NODES; n++) begin
      fn  = fx_mul(gain_q, clamp48(node_q[n] - tgt), 16);
      wfn = fx_mul(lweight_q[n], fn, 16);
      force_q[n] = clamp48(force_q[n] - wfn);
      stiff_q[n*pea_pkg::NODES+n] =
        clamp48(stiff_q[n*pea_pkg::NODES+n] - fx_mul(lweight_q[n], gain_q, 16));
      react_q = clamp48(react_q + wfn);
    end
    for (int n = 0; n < pea_pkg::NODES; n++)
      expected_entries.insert(expected_entries.size(),
                              make_entry(pea_pkg::KIND_FORCE, n, 0, force_q[n], 1'b0));
    for (int i = 0; i < pea_pkg::N_STIFF; i++)
      expected_entries.insert(expected_entries.size(),
                              make_entry(pea_pkg::KIND_STIFF, i / pea_pkg::NODES,
                                         i % pea_pkg::NODES, stiff_q[i],
                                         i == pea_pkg::N_STIFF - 1));
    clear_element();
  endfunction

  // Input driver: a new word goes out at the falling edge once the previous
  // one was taken, unless this cycle is chosen as an idle cycle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || words_taken == words_issued)) begin
      if (pending_words.size() > 0 && (quiet_stretch || $urandom_range(99) >= 11)) begin
        cur_word = pending_words.pop_front();
        in_valid_i     <= 1'b1;
        req_type_i     <= cur_word.req;
        node_slot_i    <= cur_word.slot;
        node_value_i   <= cur_word.value;
        shape_0_i      <= cur_word.shape[0];
        shape_1_i      <= cur_word.shape[1];
        shape_2_i      <= cur_word.shape[2];
        shape_3_i      <= cur_word.shape[3];
        point_weight_i <= cur_word.weight;
        last_point_i   <= cur_word.last;
        words_issued++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !quiet_stretch && ($urandom_range(99) < 11);
  end

  // Acceptance of input words feeds the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      assemble_word(cur_word);
      words_taken++;
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    entry_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_entries.size() == 0) begin
        $error("output word with no entry predicted");
        mismatches++;
      end else begin
        e = expected_entries.pop_front();
        if (entry_kind_o !== e.kind) begin
          $error("entry_kind: expected %0d, got %0d", e.kind, entry_kind_o);
          mismatches++;
        end
        if (row_node_o !== e.row) begin
          $error("row_node: expected %0d, got %0d", e.row, row_node_o);
          mismatches++;
        end
        if (col_node_o !== e.col) begin
          $error("col_node: expected %0d, got %0d", e.col, col_node_o);
          mismatches++;
        end
        if (entry_value_o !== e.value) begin
          $error("entry_value: expected %h, got %h", e.value, entry_value_o);
          mismatches++;
        end
        if (reaction_total_o !== e.react) begin
          $error("reaction_total: expected %h, got %h", e.react, reaction_total_o);
          mismatches++;
        end
        if (last_entry_o !== e.last) begin
          $error("last_entry: expected %0d, got %0d", e.last, last_entry_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'hFFFF_FFFF) & 32'h8000_0000 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_shape();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(16384)));
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(2 << 16);
    endcase
  endfunction

  task automatic queue_load(input int slot, input logic [31:0] v);
    in_word_t w;
    w.req = pea_pkg::REQ_LOAD;  w.slot = slot[1:0];  w.value = v;  w.weight = $urandom();
    w.last = $urandom_range(1);
    foreach (w.shape[i]) w.shape[i] = $urandom();
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_point(input logic [15:0] s0, input logic [15:0] s1,
                             input logic [15:0] s2, input logic [15:0] s3,
                             input logic [31:0] wt, input bit last);
    in_word_t w;
    w.req = pea_pkg::REQ_POINT;  w.slot = $urandom();  w.value = $urandom();
    w.shape[0] = s0;  w.shape[1] = s1;  w.shape[2] = s2;  w.shape[3] = s3;
    w.weight = wt;  w.last = last;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_other(input logic [1:0] req);
    in_word_t w;
    w.req = req;  w.slot = $urandom();  w.value = $urandom();  w.weight = $urandom();
    w.last = $urandom_range(1);
    foreach (w.shape[i]) w.shape[i] = $urandom();
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_random_point(input bit last);
    queue_point(pick_shape(), pick_shape(), pick_shape(), pick_shape(), pick_weight(), last);
  endtask

  // Waits until the block has taken every word and produced every entry,
  // then lets it finish any word that produces nothing.
  task automatic wait_idle();
    while (pending_words.size() > 0 || words_taken != words_issued ||
           expected_entries.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pea_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_register(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed elements: zero to two loads, one to four points, the last
  // one closing the element. Spare request codes and pass starts are mixed in.
  task automatic queue_random_elements(input int count);
    int points;
    for (int e = 0; e < count; e++) begin
      repeat ($urandom_range(2)) queue_load($urandom_range(pea_pkg::NODES - 1), pick_value());
      if ($urandom_range(9) == 0) queue_other(pea_pkg::REQ_START);
      if ($urandom_range(14) == 0) queue_other(REQ_SPARE);
      points = $urandom_range(1, 4);
      for (int p = 0; p < points; p++) queue_random_point(p == points - 1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;  cfg_index_i = '0;  cfg_data_i = '0;
    quiet_stretch = 1'b0;
    gain_q = 65536;  offset_q = 0;  rate_q = 0;  time_q = 0;  step_q = 0;
    upper_q = longint'(pea_pkg::UPPER_UNBOUNDED);  lumped_q = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under reset settings. Every slot is loaded before any
    // point reads it.
    queue_load(0, 32'h7FFF_FFFF);
    queue_load(1, 32'h8000_0000);
    queue_load(2, 32'h0001_0000);
    queue_load(3, 32'h0000_0000);
    queue_point(16'h7FFF, 16'h8000, 16'h4000, 16'h0000, 32'hFFFF_FFFF, 1'b1);
    queue_other(REQ_SPARE);
    queue_point(16'h4000, 16'h4000, 16'h4000, 16'h4000, 32'h0001_0000, 1'b0);
    queue_point(16'h2000, 16'hE000, 16'h1000, 16'h0800, 32'h0000_8000, 1'b1);
    queue_other(pea_pkg::REQ_START);
    queue_load(1, 32'hFFFF_0000);
    queue_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
    wait_idle();

    // A consistent point, then the mode changes within the element.
    queue_point(16'h3000, 16'h1000, 16'h0000, 16'h4000, 32'h0002_0000, 1'b0);
    wait_idle();
    write_reg(pea_pkg::CFG_LUMPED, 32'd1);
    queue_point(16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 1'b1);
    queue_point(16'h1000, 16'h1000, 16'h1000, 16'h1000, 32'h0001_0000, 1'b1);
    wait_idle();

    // Outside the time window: points are dropped and a last point clears.
    write_reg(pea_pkg::CFG_LUMPED, 32'd0);
    write_reg(pea_pkg::CFG_TIME, 32'h0001_0000);
    write_reg(pea_pkg::CFG_UPPER, 32'h0001_0000);
    queue_point(16'h4000, 16'h4000, 16'h4000, 16'h4000, 32'h0001_0000, 1'b0);
    queue_point(16'h4000, 16'h4000, 16'h4000, 16'h4000, 32'h0001_0000, 1'b1);
    queue_random_elements(6);
    wait_idle();

    // Extreme settings with random elements, a quiet stretch in the middle.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(pea_pkg::CFG_GAIN, 32'hFFFF_FFFF);
          write_reg(pea_pkg::CFG_OFFSET, 32'h7FFF_FFFF);
          write_reg(pea_pkg::CFG_RATE, 32'h8000_0000);
          write_reg(pea_pkg::CFG_TIME, 32'h8000_0000);
          write_reg(pea_pkg::CFG_STEP, 32'h7FFF_FFFF);
          write_reg(pea_pkg::CFG_UPPER, pea_pkg::UPPER_UNBOUNDED);
        end
        1: begin
          write_reg(pea_pkg::CFG_GAIN, 32'd0);
          write_reg(pea_pkg::CFG_OFFSET, 32'h8000_0000);
          write_reg(pea_pkg::CFG_RATE, 32'h7FFF_FFFF);
          write_reg(pea_pkg::CFG_TIME, 32'h7FFF_FFFF);
          write_reg(pea_pkg::CFG_STEP, 32'd0);
          write_reg(pea_pkg::CFG_LUMPED, 32'd1);
        end
        2: begin
          quiet_stretch = 1'b1;
          write_reg(pea_pkg::CFG_GAIN, 32'h0002_0000);
          write_reg(pea_pkg::CFG_OFFSET, 32'hFFFF_8000);
          write_reg(pea_pkg::CFG_RATE, 32'h0000_4000);
          write_reg(pea_pkg::CFG_TIME, 32'h0003_0000);
          write_reg(pea_pkg::CFG_STEP, 32'h0000_8000);
          write_reg(pea_pkg::CFG_LUMPED, 32'd0);
        end
        3: begin
          quiet_stretch = 1'b0;
          write_reg(pea_pkg::CFG_UPPER, 32'h8000_0000);
        end
        default: begin
          write_reg(pea_pkg::CFG_GAIN, $urandom_range(4 << 16));
          write_reg(pea_pkg::CFG_OFFSET, pick_value());
          write_reg(pea_pkg::CFG_RATE, pick_value());
          write_reg(pea_pkg::CFG_TIME, pick_value());
          write_reg(pea_pkg::CFG_STEP, $urandom() >> 1);
          write_reg(pea_pkg::CFG_UPPER,
                    $urandom_range(1) ? pea_pkg::UPPER_UNBOUNDED : $urandom());
          write_reg(pea_pkg::CFG_LUMPED, $urandom_range(1));
        end
      endcase
      queue_random_elements(16);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pea_pkg.sv
rtl/core/pea_mul.sv
rtl/core/penalty_element_assembly.sv
sim/penalty_element_assembly_tb.sv
